[rtl/core/sound_command_stream_translator_macros.svh]
// Assertion helpers shared by the translator RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SOUND_COMMAND_STREAM_TRANSLATOR_MACROS_SVH
`define SOUND_COMMAND_STREAM_TRANSLATOR_MACROS_SVH

// Same-cycle implication.
`define SCTR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SCTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sctr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_pkg
// Shared types, command codes and lookup tables of the command stream translator.
// ----------------------------------------------------------------------------
package sctr_pkg;

	localparam int PAD_ALIGN = 16;
	localparam int CNT_W     = (PAD_ALIGN > 2) ? $clog2(PAD_ALIGN) : 1;

	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = $clog2(JQ_DEPTH);

	// command and address codes
	localparam logic [7:0] CMD_WAIT       = 8'h61;
	localparam logic [7:0] CMD_REGW       = 8'hb3;
	localparam logic [7:0] CMD_END        = 8'h66;
	localparam logic [7:0] ADDR_MASK_HI   = 8'h70;
	localparam logic [7:0] ADDR_MASK_MID  = 8'h73;
	localparam logic [7:0] DATA_MASK_HI   = 8'h80;
	localparam logic [7:0] DATA_MASK_MID  = 8'h60;
	localparam logic [3:0] WAVE_OFF_HI    = 4'h2;
	localparam logic [3:0] WAVE_ADDR_HI   = 4'h9;
	localparam logic [7:0] WAVE_FOLLOW_AD = 8'h70;
	localparam logic [7:0] WAVE_FOLLOW_DT = 8'h40;
	localparam logic [7:0] DIRECT_OFF_LIM = 8'h20;

	// configuration registers
	localparam logic [0:0]  REG_WAIT_SCALE   = 1'b0;
	localparam logic [0:0]  REG_CYCLES       = 1'b1;
	localparam logic [11:0] WAIT_SCALE_RESET = 12'd1972;
	localparam logic [9:0]  CYCLES_RESET     = 10'd380;

	// floor(p / 1000) = (p * RECIP_1000) >> RECIP_SHIFT for p < 2^28
	localparam logic [28:0] RECIP_1000  = 29'd274877907;
	localparam int          RECIP_SHIFT = 38;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CMD    = 2'd1,
		ST_BAD_OFFSET = 2'd2,
		ST_ZERO_WAIT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		JK_WAIT,
		JK_REG,
		JK_END,
		JK_ERR
	} kind_t;

	// one classified command handed from the parser to the emitter
	typedef struct packed {
		kind_t      kind;
		logic [7:0] arg0;   // wait: count low; reg: mapped address
		logic [7:0] arg1;   // wait: count high; reg: masked data
		status_t    status;
	} job_t;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_WAIT_LO,
		PH_WAIT_HI,
		PH_REG_OFF,
		PH_REG_DATA
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL1,
		BK_MUL2,
		BK_MUL3,
		BK_EMIT,
		BK_HALT
	} back_state_t;

	localparam logic [7:0] ADDR_MAP [32] = '{
		8'h60, 8'h62, 8'h63, 8'h64, 8'h65, 8'h00, 8'h68, 8'h69,
		8'h6c, 8'h6d, 8'h70, 8'h72, 8'h73, 8'h74, 8'h75, 8'h00,
		8'h78, 8'h79, 8'h7c, 8'h7d, 8'h80, 8'h81, 8'h84, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// zero means the offset has no mapping
	function automatic logic [7:0] map_offset(input logic [7:0] off);
		logic [7:0] res;
		if (off[7:4] == WAVE_OFF_HI) begin
			res = {WAVE_ADDR_HI, off[3:0]};
		end else if (off < DIRECT_OFF_LIM) begin
			res = ADDR_MAP[off[4:0]];
		end else begin
			res = 8'h00;
		end
		return res;
	endfunction

endpackage

[rtl/core/sound_command_stream_translator.sv]
`timescale 1ns / 1ps
// Sound command stream translator.
// Input channel: one command byte per transaction (in_valid / in_stall / in_byte).
// Output channel: one translated byte per transaction with last and status flags.
// A front parser classifies bytes into jobs and queues up to four of them; a
// back emitter turns each job into output bytes, one byte per cycle unless
// the receiver stalls. A register write is dispatched from the queue and then
// emitted; a wait first runs count*scale, a reciprocal multiply for /1000 and
// the reload multiply before its 5 bytes start. The emitter bounds throughput:
// it spends a dispatch state on each job and takes no new job before the last
// one is out; each wait or register write costs 3 input bytes.
// End (0x66) is echoed and zero padded to a 16-byte boundary with last on the
// final pad byte; an error gives one byte with last set and a status code.
// After either, the block swallows all input until reset.
// Reset: parser to command phase, queue empty, config to 1972 and 380.
// A stalled receiver holds the output register; the queue then fills and
// in_stall rises, without losing or repeating any transaction.
// ----------------------------------------------------------------------------
// sound_command_stream_translator
// Top level: configuration registers and the parser / queue / emitter chain.
// ----------------------------------------------------------------------------
module sound_command_stream_translator import sctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  status
);

	logic [11:0] wait_scale_q;
	logic [9:0]  cycles_q;
	logic        cfg_wr;
	logic        q_push;
	job_t        q_push_job;
	logic        q_full;
	logic        q_pop;
	logic        q_valid;
	job_t        q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_scale_q <= WAIT_SCALE_RESET;
			cycles_q     <= CYCLES_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WAIT_SCALE: wait_scale_q <= pwdata[11:0];
				REG_CYCLES:     cycles_q     <= pwdata[9:0];
				default:        cycles_q     <= cycles_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WAIT_SCALE: prdata = {20'b0, wait_scale_q};
			REG_CYCLES:     prdata = {22'b0, cycles_q};
			default:        prdata = 32'b0;
		endcase
	end

	sctr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_push_job)
	);

	sctr_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_head)
	);

	sctr_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.wait_scale        (wait_scale_q),
		.cycles_per_sample (cycles_q),
		.q_valid           (q_valid),
		.q_job             (q_head),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_byte          (out_byte),
		.last              (last),
		.status            (status)
	);

endmodule

[rtl/core/sctr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_front
// Byte parser: tracks command phase, remaps offsets and pushes classified jobs.
// ----------------------------------------------------------------------------
module sctr_front import sctr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job
);

	phase_t     phase_q, phase_d;
	logic [7:0] held_q;
	logic       stopped_q;
	logic       act;
	logic       hold_load;
	logic [7:0] hold_val;
	logic       set_stop;
	logic [7:0] mapped;
	logic [7:0] data_m;

	// once halted every byte is swallowed
	assign in_stall = !stopped_q && q_full;
	assign act      = in_valid && !in_stall && !stopped_q;
	assign mapped   = map_offset(in_byte);

	always_comb begin
		data_m = in_byte;
		if (held_q == ADDR_MASK_HI) begin
			data_m = in_byte & DATA_MASK_HI;
		end else if (held_q == ADDR_MASK_MID) begin
			data_m = in_byte & DATA_MASK_MID;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (act) begin
			case (phase_q)
				PH_CMD: begin
					if (in_byte == CMD_WAIT) begin
						phase_d = PH_WAIT_LO;
					end else if (in_byte == CMD_REGW) begin
						phase_d = PH_REG_OFF;
					end
				end
				PH_WAIT_LO:  phase_d = PH_WAIT_HI;
				PH_WAIT_HI:  phase_d = PH_CMD;
				PH_REG_OFF: begin
					if (mapped != 8'h00) begin
						phase_d = PH_REG_DATA;
					end
				end
				PH_REG_DATA: phase_d = PH_CMD;
				default:     phase_d = PH_CMD;
			endcase
		end
	end

	// outputs
	always_comb begin
		q_push    = 1'b0;
		q_job     = '{kind: JK_END, arg0: 8'h00, arg1: 8'h00, status: ST_OK};
		hold_load = 1'b0;
		hold_val  = in_byte;
		set_stop  = 1'b0;
		if (act) begin
			case (phase_q)
				PH_CMD: begin
					if (in_byte == CMD_END) begin
						q_push   = 1'b1;
						set_stop = 1'b1;
					end else if (in_byte != CMD_WAIT && in_byte != CMD_REGW) begin
						q_push       = 1'b1;
						q_job.kind   = JK_ERR;
						q_job.status = ST_BAD_CMD;
						set_stop     = 1'b1;
					end
				end
				PH_WAIT_LO: begin
					hold_load = 1'b1;
				end
				PH_WAIT_HI: begin
					q_push     = 1'b1;
					q_job.kind = JK_WAIT;
					q_job.arg0 = held_q;
					q_job.arg1 = in_byte;
				end
				PH_REG_OFF: begin
					if (mapped == 8'h00) begin
						q_push       = 1'b1;
						q_job.kind   = JK_ERR;
						q_job.status = ST_BAD_OFFSET;
						set_stop     = 1'b1;
					end else begin
						hold_load = 1'b1;
						hold_val  = mapped;
					end
				end
				PH_REG_DATA: begin
					q_push     = 1'b1;
					q_job.kind = JK_REG;
					q_job.arg0 = held_q;
					q_job.arg1 = data_m;
				end
				default: begin
					q_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CMD;
			held_q    <= 8'h00;
			stopped_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (hold_load) begin
				held_q <= hold_val;
			end
			if (set_stop) begin
				stopped_q <= 1'b1;
			end
		end
	end

endmodule

[rtl/core/sctr_jobq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_jobq
// Small FIFO of classified jobs between the parser and the emitter.
// ----------------------------------------------------------------------------
`include "sound_command_stream_translator_macros.svh"
module sctr_jobq import sctr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t             slot_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_ptr_q;
	logic [JQ_AW-1:0] rd_ptr_q;
	logic [JQ_AW:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == (JQ_AW+1)'(JQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SCTR_ASSERT_IMPL(a_jobq_bound, 1'b1, count_q <= (JQ_AW+1)'(JQ_DEPTH), "job queue overflow")
	`SCTR_ASSERT_IMPL(a_jobq_no_drop, push, !full, "job pushed into a full queue")

endmodule

[rtl/core/sctr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_back
// Emitter: computes timer reloads and streams translated bytes with padding.
// ----------------------------------------------------------------------------
`include "sound_command_stream_translator_macros.svh"
module sctr_back import sctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] wait_scale,
	input  logic [9:0]  cycles_per_sample,
	input  logic        q_valid,
	input  job_t        q_job,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  status
);

	back_state_t      state_q, state_d;
	job_t             job_q;
	logic [2:0]       idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [27:0]      prod_s1;
	logic [18:0]      quot_s2;
	logic [31:0]      reload_s3;
	logic [56:0]      recip_full;
	logic [28:0]      cyc_prod;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	status_t          status_q;

	logic             slot_free;
	logic             load_out;
	logic             take_job;
	logic [7:0]       cur_byte;
	logic             cur_last;
	logic             is_final;
	logic             cnt_wrap;
	logic             wave;

	function automatic logic [15:0] q_job_count(input job_t j);
		return {j.arg1, j.arg0};
	endfunction

	assign slot_free  = !out_valid_q || !out_stall;
	assign cnt_wrap   = (cnt_q == CNT_W'(PAD_ALIGN - 1));
	assign wave       = (job_q.arg0[7:4] == WAVE_ADDR_HI);
	assign recip_full = {29'b0, prod_s1} * {28'b0, RECIP_1000};
	assign cyc_prod   = {19'd0, cycles_per_sample} * {10'd0, quot_s2};

	// byte selection for the current job
	always_comb begin
		cur_byte = 8'h00;
		cur_last = 1'b0;
		is_final = 1'b0;
		case (job_q.kind)
			JK_WAIT: begin
				case (idx_q)
					3'd0:    cur_byte = CMD_WAIT;
					3'd1:    cur_byte = reload_s3[7:0];
					3'd2:    cur_byte = reload_s3[15:8];
					3'd3:    cur_byte = reload_s3[23:16];
					default: cur_byte = reload_s3[31:24];
				endcase
				is_final = (idx_q == 3'd4);
			end
			JK_REG: begin
				case (idx_q)
					3'd0:    cur_byte = CMD_REGW;
					3'd1:    cur_byte = job_q.arg0;
					3'd2:    cur_byte = job_q.arg1;
					3'd3:    cur_byte = CMD_REGW;
					3'd4:    cur_byte = WAVE_FOLLOW_AD;
					default: cur_byte = WAVE_FOLLOW_DT;
				endcase
				is_final = (idx_q == 3'd5) || (idx_q == 3'd2 && !wave);
			end
			JK_END: begin
				// echo, then zeros until the running count lands on a boundary
				cur_byte = (idx_q == 3'd0) ? CMD_END : 8'h00;
				cur_last = (idx_q != 3'd0) && cnt_wrap;
				is_final = cur_last;
			end
			default: begin
				cur_last = 1'b1;
				is_final = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = (q_job.kind == JK_WAIT) ? BK_MUL1 : BK_EMIT;
				end
			end
			BK_MUL1: state_d = BK_MUL2;
			BK_MUL2: state_d = BK_MUL3;
			BK_MUL3: state_d = BK_EMIT;
			BK_EMIT: begin
				if (slot_free && is_final) begin
					state_d = (job_q.kind == JK_END || job_q.kind == JK_ERR) ?
						BK_HALT : BK_IDLE;
				end
			end
			BK_HALT: state_d = BK_HALT;
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = 1'b0;
		take_job = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop    = q_valid;
				take_job = q_valid;
			end
			BK_EMIT: load_out = slot_free;
			BK_HALT: q_pop = q_valid;   // drain and discard
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_MUL1) begin
			prod_s1 <= {12'd0, q_job_count(job_q)} * {16'd0, wait_scale};
		end
		if (state_q == BK_MUL2) begin
			quot_s2 <= recip_full[RECIP_SHIFT +: 19];
		end
		if (state_q == BK_MUL3) begin
			reload_s3 <= 32'd0 - {3'b0, cyc_prod};
		end
		if (load_out) begin
			out_byte_q <= cur_byte;
			last_q     <= cur_last;
			status_q   <= job_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			job_q       <= '{kind: JK_END, arg0: 8'h00, arg1: 8'h00, status: ST_OK};
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_job) begin
				job_q <= q_job;
				idx_q <= '0;
			end
			// a zero product turns the wait into an error result
			if (state_q == BK_MUL3 && (quot_s2 == '0 || cycles_per_sample == '0)) begin
				job_q.kind   <= JK_ERR;
				job_q.status <= ST_ZERO_WAIT;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (idx_q != 3'd7) begin
					idx_q <= idx_q + 1'b1;
				end
				if (job_q.kind != JK_ERR) begin
					cnt_q <= cnt_wrap ? '0 : cnt_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign status    = status_q;

	`SCTR_ASSERT_IMPL(a_no_overwrite, out_valid_q && out_stall, !load_out,
		"pending output overwritten")
	`SCTR_ASSERT_NEXT(a_halt_quiet, state_q == BK_HALT && !out_valid_q, !out_valid_q,
		"output after halt")
	`SCTR_ASSERT_NEXT(a_mul_order, state_q == BK_MUL1, state_q == BK_MUL2,
		"reload sequence broken")

endmodule

[sim/sound_command_stream_translator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_command_stream_translator_test
// Self-checking bench for the command stream translator. Wait and register
// write commands go in byte by byte under random idling on both channels,
// over several wait scale / cycle settings. A bench-side translator predicts
// every output byte, and a checker compares each output transaction with it.
// The run ends with one end or error command, since either one halts the block.
// ----------------------------------------------------------------------------
module sound_command_stream_translator_test import sctr_pkg::*;;

	localparam int          CYCLE_LIMIT = 500000;
	localparam int          SETTLE      = 24;
	localparam logic [2:0]  SCALE_ADDR  = {REG_WAIT_SCALE, 2'b00};
	localparam logic [2:0]  CYCLES_ADDR = {REG_CYCLES, 2'b00};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		status_t    st;
	} out_rec_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic [1:0]  status;

	sound_command_stream_translator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// translator mirror
	out_rec_t    pending_bytes[$];
	phase_t      parse_ph  = PH_CMD;
	logic [7:0]  held      = '0;
	int unsigned pad_cnt   = 0;
	bit          halted    = 1'b0;
	logic [11:0] scale_cfg = WAIT_SCALE_RESET;
	logic [9:0]  cyc_cfg   = CYCLES_RESET;

	int err_cnt    = 0;
	int cycle_cnt  = 0;
	int items_sent = 0;
	bit bursty     = 1'b0;
	int stall_run  = 0;

	task automatic report(input string what, input int got, input int want);
		if (err_cnt < 40)
			$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	function automatic logic [7:0] reg_addr(input logic [7:0] off);
		if (off >= 8'h20 && off <= 8'h2f)
			return {WAVE_ADDR_HI, off[3:0]};
		case (off)
			8'h00: return 8'h60;
			8'h01: return 8'h62;
			8'h02: return 8'h63;
			8'h03: return 8'h64;
			8'h04: return 8'h65;
			8'h06: return 8'h68;
			8'h07: return 8'h69;
			8'h08: return 8'h6c;
			8'h09: return 8'h6d;
			8'h0a: return 8'h70;
			8'h0b: return 8'h72;
			8'h0c: return 8'h73;
			8'h0d: return 8'h74;
			8'h0e: return 8'h75;
			8'h10: return 8'h78;
			8'h11: return 8'h79;
			8'h12: return 8'h7c;
			8'h13: return 8'h7d;
			8'h14: return 8'h80;
			8'h15: return 8'h81;
			8'h16: return 8'h84;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [31:0] timer_ticks(input logic [15:0] count);
		logic [31:0] samples;
		samples = ({16'd0, count} * {20'd0, scale_cfg}) / 32'd1000;
		return {22'd0, cyc_cfg} * samples;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic lst);
		pending_bytes.push_back('{data: b, last: lst, st: ST_OK});
		pad_cnt = (pad_cnt + 1) % PAD_ALIGN;
	endtask

	task automatic push_error(input status_t code);
		pending_bytes.push_back('{data: 8'h00, last: 1'b1, st: code});
		halted = 1'b1;
	endtask

	task automatic translate_byte(input logic [7:0] b);
		logic [31:0] ticks;
		logic [31:0] reload;
		logic [7:0]  addr;
		logic [7:0]  dat;
		int unsigned pad;
		if (halted)
			return;
		case (parse_ph)
			PH_CMD: begin
				if (b == CMD_WAIT) begin
					parse_ph = PH_WAIT_LO;
				end else if (b == CMD_REGW) begin
					parse_ph = PH_REG_OFF;
				end else if (b == CMD_END) begin
					push_byte(CMD_END, 1'b0);
					pad = PAD_ALIGN - pad_cnt;
					for (int i = 0; i < pad; i++)
						push_byte(8'h00, i == pad - 1);
					halted = 1'b1;
				end else begin
					push_error(ST_BAD_CMD);
				end
			end
			PH_WAIT_LO: begin
				held     = b;
				parse_ph = PH_WAIT_HI;
			end
			PH_WAIT_HI: begin
				ticks    = timer_ticks({b, held});
				reload   = 32'd0 - ticks;
				parse_ph = PH_CMD;
				if (ticks == 0) begin
					push_error(ST_ZERO_WAIT);
				end else begin
					push_byte(CMD_WAIT, 1'b0);
					push_byte(reload[7:0], 1'b0);
					push_byte(reload[15:8], 1'b0);
					push_byte(reload[23:16], 1'b0);
					push_byte(reload[31:24], 1'b0);
				end
			end
			PH_REG_OFF: begin
				addr = reg_addr(b);
				if (addr == 8'h00) begin
					push_error(ST_BAD_OFFSET);
				end else begin
					held     = addr;
					parse_ph = PH_REG_DATA;
				end
			end
			PH_REG_DATA: begin
				dat = b;
				if (held == ADDR_MASK_HI)
					dat &= DATA_MASK_HI;
				if (held == ADDR_MASK_MID)
					dat &= DATA_MASK_MID;
				push_byte(CMD_REGW, 1'b0);
				push_byte(held, 1'b0);
				push_byte(dat, 1'b0);
				// wave RAM writes get a trailing control write
				if (held[7:4] == WAVE_ADDR_HI) begin
					push_byte(CMD_REGW, 1'b0);
					push_byte(WAVE_FOLLOW_AD, 1'b0);
					push_byte(WAVE_FOLLOW_DT, 1'b0);
				end
				parse_ph = PH_CMD;
			end
			default: parse_ph = PH_CMD;
		endcase
	endtask

	// output checker
	always @(posedge clk) begin
		out_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				report("unexpected output byte", out_byte, 0);
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.data)
					report("out_byte", out_byte, want.data);
				if (last !== want.last)
					report("last", last, want.last);
				if (status !== want.st)
					report("status", status, want.st);
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_run > 0)
			stall_run--;
		else if (bursty && $urandom_range(0, 6) == 0)
			stall_run = $urandom_range(1, 18);
		out_stall <= (stall_run > 0);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("sound_command_stream_translator_test: errors");
			$finish;
		end
	end

	// one input transaction; leaves valid high at the accepting edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (bursty && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		translate_byte(b);
		items_sent++;
	endtask

	task automatic send_wait(input logic [15:0] count);
		send_byte(CMD_WAIT);
		send_byte(count[7:0]);
		send_byte(count[15:8]);
	endtask

	task automatic send_regw(input logic [7:0] off, input logic [7:0] dat);
		send_byte(CMD_REGW);
		send_byte(off);
		send_byte(dat);
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata   = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_regs();
		logic [31:0] rd;
		apb_access(1'b0, SCALE_ADDR, 32'd0, rd);
		if (rd[11:0] !== scale_cfg)
			report("wait_scale_milli readback", rd[11:0], scale_cfg);
		apb_access(1'b0, CYCLES_ADDR, 32'd0, rd);
		if (rd[9:0] !== cyc_cfg)
			report("cycles_per_sample readback", rd[9:0], cyc_cfg);
	endtask

	// junk above the register width must be dropped
	task automatic program_timing(input logic [11:0] scale, input logic [9:0] cyc);
		logic [31:0] rd;
		drain_output();
		apb_access(1'b1, SCALE_ADDR, {20'($urandom_range(0, 1048575)), scale}, rd);
		scale_cfg = scale;
		apb_access(1'b1, CYCLES_ADDR, {22'($urandom_range(0, 4194303)), cyc}, rd);
		cyc_cfg = cyc;
		check_regs();
	endtask

	task automatic send_random_cmd();
		logic [15:0] count;
		logic [7:0]  off;
		logic [7:0]  dat;
		if (scale_cfg != 0 && cyc_cfg != 0 && $urandom_range(0, 2) == 0) begin
			count = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
			// keep the product nonzero so the run is not halted
			if (timer_ticks(count) == 0)
				count |= 16'hfc00;
			send_wait(count);
		end else begin
			do off = 8'($urandom_range(0, 8'h2f)); while (reg_addr(off) == 8'h00);
			case ($urandom_range(0, 5))
				0: dat = 8'h00;
				1: dat = 8'hff;
				default: dat = 8'($urandom);
			endcase
			send_regw(off, dat);
		end
	endtask

	task automatic send_traffic(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at)
			send_random_cmd();
	endtask

	task automatic test_reset_values();
		check_regs();
	endtask

	task automatic test_directed();
		bursty = 1'b0;
		send_regw(8'h00, 8'h00);
		send_regw(8'h0a, 8'hff);
		send_regw(8'h0c, 8'hff);
		send_regw(8'h20, 8'h5a);
		send_regw(8'h2f, 8'hff);
		send_regw(8'h16, 8'ha5);
		send_wait(16'hffff);
		send_wait(16'h0001);
	endtask

	task automatic test_max_timing();
		program_timing(12'd4095, 10'd1023);
		bursty = 1'b1;
		send_traffic(40);
	endtask

	// zero scale or zero cycles: any wait would be an error, so only writes
	task automatic test_zero_scale();
		program_timing(12'd0, 10'($urandom_range(1, 1023)));
		send_traffic(24);
	endtask

	task automatic test_min_timing();
		program_timing(12'd1, 10'd1);
		send_traffic(30);
	endtask

	task automatic test_zero_cycles();
		program_timing(12'($urandom_range(1, 4095)), 10'd0);
		send_traffic(24);
	endtask

	task automatic test_random_traffic();
		program_timing(12'($urandom_range(1, 4095)), 10'($urandom_range(1, 1023)));
		for (int chunk = 0; chunk < 3; chunk++) begin
			bursty = $urandom_range(0, 2) != 0;
			send_traffic(25);
			// hold off until the output side has caught up
			drain_output();
		end
	endtask

	task automatic test_steady();
		program_timing(WAIT_SCALE_RESET, CYCLES_RESET);
		bursty = 1'b0;
		send_traffic(20);
	endtask

	// one halting command, then bytes that must be swallowed
	task automatic test_terminal();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: send_byte(CMD_END);
			1: begin
				do b = 8'($urandom);
				while (b == CMD_WAIT || b == CMD_REGW || b == CMD_END);
				send_byte(b);
			end
			2: begin
				send_byte(CMD_REGW);
				do b = 8'($urandom); while (reg_addr(b) != 8'h00);
				send_byte(b);
			end
			default: send_wait(16'($urandom_range(0, 999 / scale_cfg)));
		endcase
		repeat (20) begin
			case ($urandom_range(0, 3))
				0: send_byte(CMD_WAIT);
				1: send_byte(CMD_REGW);
				2: send_byte(CMD_END);
				default: send_byte(8'($urandom));
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_max_timing();
		test_zero_scale();
		test_min_timing();
		test_zero_cycles();
		test_random_traffic();
		test_steady();
		test_terminal();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("sound_command_stream_translator_test: clean");
		else
			$display("sound_command_stream_translator_test: errors");
		$finish;
	end

endmodule
